@@ hdl/lfdo_pkg.sv @@
`timescale 1ns / 1ps

package lfdo_pkg;

  localparam int unsigned DEPTH    = 8192;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned CW       = AW + 1;
  localparam int unsigned LINE_MAX = 256;
  localparam int unsigned LW       = $clog2(LINE_MAX);
  localparam int unsigned DW       = 24;

  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [DW-1:0] DROP_MAX = {DW{1'b1}};

  localparam logic [2:0] REQ_BEGIN   = 3'd0;
  localparam logic [2:0] REQ_WRITE   = 3'd1;
  localparam logic [2:0] REQ_PEEK    = 3'd2;
  localparam logic [2:0] REQ_CONSUME = 3'd3;
  localparam logic [2:0] REQ_TAKE    = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_IGNORED  = 2'd2;

  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_QM = 8'h3F;
  localparam logic [7:0] BYTE_FF = 8'hFF;

  localparam logic [13:0] THRESH_RST   = 14'd256;
  localparam logic [8:0]  MAX_LINE_RST = 9'd256;

  localparam logic REG_THRESH   = 1'b0;
  localparam logic REG_MAX_LINE = 1'b1;

  typedef enum logic [2:0] {
    OP_BEGIN,
    OP_WRITE,
    OP_PEEK,
    OP_CONSUME,
    OP_TAKE,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e           op;
    logic [LW-1:0] len;
    logic          capped;
    logic [7:0]    data;
    logic [AW-1:0] offset;
    logic [CW-1:0] count;
  } cmd_t;

endpackage

@@ hdl/lfdo_front.sv @@
`timescale 1ns / 1ps

module lfdo_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           req_type_i,
  input  logic [15:0]          line_len_i,
  input  logic [7:0]           data_byte_i,
  input  logic [12:0]          peek_offset_i,
  input  logic [13:0]          consume_count_i,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output logic [13:0]          threshold_o,
  output logic                 push_o,
  output lfdo_pkg::cmd_t       cmd_o,
  input  logic                 full_i
);

  logic [13:0] thresh_q;
  logic [8:0]  max_line_q;
  logic [8:0]  eff_max;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q   <= lfdo_pkg::THRESH_RST;
      max_line_q <= lfdo_pkg::MAX_LINE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == lfdo_pkg::REG_THRESH) begin
        thresh_q <= pwdata[13:0];
      end else begin
        max_line_q <= pwdata[8:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == lfdo_pkg::REG_MAX_LINE) begin
      prdata = {23'd0, max_line_q};
    end else begin
      prdata = {18'd0, thresh_q};
    end
  end

  assign threshold_o = thresh_q;

  // clamp max_line to its usable range
  always_comb begin
    if (max_line_q < 9'd2) begin
      eff_max = 9'd2;
    end else if (max_line_q > 9'(lfdo_pkg::LINE_MAX)) begin
      eff_max = 9'(lfdo_pkg::LINE_MAX);
    end else begin
      eff_max = max_line_q;
    end
  end

  always_comb begin
    cmd_o.data   = (data_byte_i == lfdo_pkg::BYTE_FF) ? lfdo_pkg::CHAR_QM : data_byte_i;
    cmd_o.offset = peek_offset_i;
    cmd_o.count  = consume_count_i;
    if (line_len_i >= {7'd0, eff_max}) begin
      cmd_o.len    = lfdo_pkg::LW'(eff_max - 9'd1);
      cmd_o.capped = 1'b1;
    end else begin
      cmd_o.len    = line_len_i[lfdo_pkg::LW-1:0];
      cmd_o.capped = 1'b0;
    end
    case (req_type_i)
      lfdo_pkg::REQ_BEGIN:   cmd_o.op = lfdo_pkg::OP_BEGIN;
      lfdo_pkg::REQ_WRITE:   cmd_o.op = lfdo_pkg::OP_WRITE;
      lfdo_pkg::REQ_PEEK:    cmd_o.op = lfdo_pkg::OP_PEEK;
      lfdo_pkg::REQ_CONSUME: cmd_o.op = lfdo_pkg::OP_CONSUME;
      lfdo_pkg::REQ_TAKE:    cmd_o.op = lfdo_pkg::OP_TAKE;
      default:               cmd_o.op = lfdo_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

endmodule

@@ hdl/lfdo_queue.sv @@
`timescale 1ns / 1ps

module lfdo_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lfdo_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           valid_o,
  output lfdo_pkg::cmd_t cmd_o,
  input  logic           pop_i
);

  lfdo_pkg::cmd_t ent_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ hdl/lfdo_back.sv @@
`timescale 1ns / 1ps

module lfdo_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  lfdo_pkg::cmd_t cmd_i,
  output logic           pop_o,
  input  logic [13:0]    threshold_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     status_o,
  output logic [7:0]     read_byte_o,
  output logic [13:0]    used_bytes_o,
  output logic [23:0]    dropped_count_o,
  output logic           flush_due_o
);

  localparam int unsigned AW = lfdo_pkg::AW;
  localparam int unsigned CW = lfdo_pkg::CW;
  localparam int unsigned LW = lfdo_pkg::LW;
  localparam int unsigned DW = lfdo_pkg::DW;

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_PEEK     = 2'd1;
  localparam logic [1:0] S_DROP_RD  = 2'd2;
  localparam logic [1:0] S_DROP_CHK = 2'd3;

  logic [7:0] mem [lfdo_pkg::DEPTH];

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] used_q, used_d;
  logic [DW-1:0] drop_q, drop_d;
  logic [LW-1:0] left_q, left_d;
  logic          capped_q, capped_d;
  logic [LW-1:0] pend_len_q, pend_len_d;
  logic          pend_cap_q, pend_cap_d;

  logic          wr_en;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data_q;

  logic          out_valid_q;
  logic [1:0]    status_q;
  logic [7:0]    rbyte_q;
  logic [CW-1:0] used_out_q;
  logic [DW-1:0] dc_q;
  logic          flush_q;

  logic          out_free;
  logic          start;
  logic          res_load;
  logic [1:0]    res_status;
  logic [7:0]    res_byte;
  logic [DW-1:0] res_dc;
  logic [CW-1:0] clamp_cnt;
  logic [CW-1:0] used_dec;
  logic          need_drop;
  logic          need_more;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign start    = (state_q == S_IDLE) & valid_i & out_free;
  assign pop_o    = start;

  assign clamp_cnt = (cmd_i.count > used_q) ? used_q : cmd_i.count;
  assign used_dec  = used_q - CW'(1);
  assign need_drop = ({1'b0, used_q} + (CW + 1)'(cmd_i.len)) > {1'b0, lfdo_pkg::DEPTH_C};
  assign need_more = ({1'b0, used_dec} + (CW + 1)'(pend_len_q)) > {1'b0, lfdo_pkg::DEPTH_C};

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    used_d     = used_q;
    drop_d     = drop_q;
    left_d     = left_q;
    capped_d   = capped_q;
    pend_len_d = pend_len_q;
    pend_cap_d = pend_cap_q;
    wr_en      = 1'b0;
    wr_data    = cmd_i.data;
    rd_en      = 1'b0;
    rd_addr    = tail_q;
    res_load   = 1'b0;
    res_status = lfdo_pkg::ST_OK;
    res_byte   = 8'd0;
    res_dc     = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (cmd_i.op)
            lfdo_pkg::OP_BEGIN: begin
              left_d   = '0;
              capped_d = 1'b0;
              if (CW'(cmd_i.len) > lfdo_pkg::DEPTH_C) begin
                res_load   = 1'b1;
                res_status = lfdo_pkg::ST_TOO_LONG;
              end else if (cmd_i.len == '0) begin
                res_load = 1'b1;
              end else if (need_drop) begin
                pend_len_d = cmd_i.len;
                pend_cap_d = cmd_i.capped;
                state_d    = S_DROP_RD;
              end else begin
                left_d   = cmd_i.len;
                capped_d = cmd_i.capped;
                res_load = 1'b1;
              end
            end
            lfdo_pkg::OP_WRITE: begin
              res_load = 1'b1;
              if (left_q == '0 || used_q >= lfdo_pkg::DEPTH_C) begin
                res_status = lfdo_pkg::ST_IGNORED;
              end else begin
                wr_en = 1'b1;
                if (capped_q && left_q == LW'(1)) begin
                  wr_data = lfdo_pkg::CHAR_NL;
                end
                head_d = head_q + AW'(1);
                used_d = used_q + CW'(1);
                left_d = left_q - LW'(1);
                if (left_q == LW'(1)) begin
                  capped_d = 1'b0;
                end
              end
            end
            lfdo_pkg::OP_PEEK: begin
              if (CW'(cmd_i.offset) < used_q) begin
                rd_en   = 1'b1;
                rd_addr = tail_q + cmd_i.offset;
                state_d = S_PEEK;
              end else begin
                res_load   = 1'b1;
                res_status = lfdo_pkg::ST_IGNORED;
              end
            end
            lfdo_pkg::OP_CONSUME: begin
              res_load = 1'b1;
              tail_d   = tail_q + clamp_cnt[AW-1:0];
              used_d   = used_q - clamp_cnt;
            end
            lfdo_pkg::OP_TAKE: begin
              res_load = 1'b1;
              res_dc   = drop_q;
              drop_d   = '0;
            end
            default: begin
              res_load   = 1'b1;
              res_status = lfdo_pkg::ST_IGNORED;
            end
          endcase
        end
      end
      S_PEEK: begin
        res_load = 1'b1;
        res_byte = rd_data_q;
        state_d  = S_IDLE;
      end
      S_DROP_RD: begin
        rd_en   = 1'b1;
        state_d = S_DROP_CHK;
      end
      default: begin
        tail_d = tail_q + AW'(1);
        used_d = used_dec;
        if (drop_q != lfdo_pkg::DROP_MAX) begin
          drop_d = drop_q + DW'(1);
        end
        // line ends at its newline or when nothing is left
        if ((rd_data_q == lfdo_pkg::CHAR_NL || used_dec == '0) && !need_more) begin
          left_d   = pend_len_q;
          capped_d = pend_cap_q;
          res_load = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_DROP_RD;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[head_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      used_q      <= '0;
      drop_q      <= '0;
      left_q      <= '0;
      capped_q    <= 1'b0;
      pend_len_q  <= '0;
      pend_cap_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      used_q      <= used_d;
      drop_q      <= drop_d;
      left_q      <= left_d;
      capped_q    <= capped_d;
      pend_len_q  <= pend_len_d;
      pend_cap_q  <= pend_cap_d;
      out_valid_q <= res_load | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      status_q   <= res_status;
      rbyte_q    <= res_byte;
      used_out_q <= used_d;
      dc_q       <= res_dc;
      flush_q    <= (used_d >= threshold_i);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign read_byte_o     = rbyte_q;
  assign used_bytes_o    = used_out_q;
  assign dropped_count_o = dc_q;
  assign flush_due_o     = flush_q;

endmodule

@@ hdl/line_fifo_drop_oldest_top.sv @@
`timescale 1ns / 1ps

// byte fifo for text log lines, oldest whole lines dropped to make room
// input channel: in_valid_i / in_stall_o, one request word per accepted edge
// output channel: out_valid_o / out_stall_i, exactly one result word per request
// registers over the apb port: flush threshold at 0x0, max line size at 0x4
// requests pass a decoder into a two-entry queue, then the execution unit
// begin, write, consume and take pass the queue and the output register; a peek also passes the byte store read
// throughput: one word per cycle while the execution unit is free and no stalled result holds the output register
// a peek holds the execution unit for its byte store read, through the S_PEEK state
// a begin that needs room holds it while each dropped byte passes S_DROP_RD (read), then S_DROP_CHK (test)
// a stalled result stays in the output register; the queue keeps accepting
// until it is full, then in_stall_o rises
// reset empties the fifo, clears the drop count and the open line, and sets
// threshold 256 and max line 256; no clearing pass is needed
module line_fifo_drop_oldest_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [15:0] line_len_i,
  input  logic [7:0]  data_byte_i,
  input  logic [12:0] peek_offset_i,
  input  logic [13:0] consume_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  read_byte_o,
  output logic [13:0] used_bytes_o,
  output logic [23:0] dropped_count_o,
  output logic        flush_due_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic           push;
  logic           full;
  logic           q_valid;
  logic           pop;
  logic [13:0]    threshold;
  lfdo_pkg::cmd_t cmd_in;
  lfdo_pkg::cmd_t cmd_out;

  lfdo_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .line_len_i      (line_len_i),
    .data_byte_i     (data_byte_i),
    .peek_offset_i   (peek_offset_i),
    .consume_count_i (consume_count_i),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .threshold_o     (threshold),
    .push_o          (push),
    .cmd_o           (cmd_in),
    .full_i          (full)
  );

  lfdo_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .valid_o (q_valid),
    .cmd_o   (cmd_out),
    .pop_i   (pop)
  );

  lfdo_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .cmd_i           (cmd_out),
    .pop_o           (pop),
    .threshold_i     (threshold),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .read_byte_o     (read_byte_o),
    .used_bytes_o    (used_bytes_o),
    .dropped_count_o (dropped_count_o),
    .flush_due_o     (flush_due_o)
  );

endmodule

@@ tb/line_fifo_drop_oldest_top_test.sv @@
`timescale 1ns / 1ps

module line_fifo_drop_oldest_top_test;

  localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned IW = lfdo_pkg::AW;

  typedef struct packed {
    logic [2:0]  req;
    logic [15:0] len;
    logic [7:0]  data;
    logic [12:0] off;
    logic [13:0] cnt;
  } word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  rd;
    logic [13:0] used;
    logic [23:0] dropped;
    logic        due;
  } result_t;

  typedef struct packed {
    logic        is_cfg;
    logic        typed;
    word_t       w;
    result_t     want;
    logic        cfg_sel;
    logic [31:0] cfg_val;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  req_type_i;
  logic [15:0] line_len_i;
  logic [7:0]  data_byte_i;
  logic [12:0] peek_offset_i;
  logic [13:0] consume_count_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [7:0]  read_byte_o;
  logic [13:0] used_bytes_o;
  logic [23:0] dropped_count_o;
  logic        flush_due_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  line_fifo_drop_oldest_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .line_len_i      (line_len_i),
    .data_byte_i     (data_byte_i),
    .peek_offset_i   (peek_offset_i),
    .consume_count_i (consume_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .read_byte_o     (read_byte_o),
    .used_bytes_o    (used_bytes_o),
    .dropped_count_o (dropped_count_o),
    .flush_due_o     (flush_due_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // shadow copy of the fifo
  logic [7:0]  fifo_mem [lfdo_pkg::DEPTH];
  int unsigned wr_ptr;
  int unsigned rd_ptr;
  int unsigned fill;
  logic [23:0] drop_cnt;
  int unsigned bytes_left;
  logic        cut_line;
  int unsigned cfg_thresh;
  int unsigned cfg_max_line;

  result_t     pending_results [$];
  row_t        dir_rows [$];
  int          errors;
  int unsigned cycles;
  logic        steady;
  int          holdoff_asks;
  int          holdoff_seen;
  int          holdoff_left;

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned line_cap();
    int unsigned m;
    m = cfg_max_line;
    if (m < 2) m = 2;
    if (m > lfdo_pkg::LINE_MAX) m = lfdo_pkg::LINE_MAX;
    return m;
  endfunction

  // oldest line through its newline, or until empty
  function automatic void drop_line();
    logic [7:0] b;
    logic       done;
    done = 1'b0;
    while (fill > 0 && !done) begin
      b = fifo_mem[rd_ptr[IW-1:0]];
      rd_ptr = (rd_ptr + 1) % lfdo_pkg::DEPTH;
      fill--;
      if (drop_cnt != lfdo_pkg::DROP_MAX) drop_cnt++;
      if (b == lfdo_pkg::CHAR_NL) done = 1'b1;
    end
  endfunction

  function automatic result_t fifo_step(word_t w);
    result_t     r;
    int unsigned n;
    logic        cap;
    logic [7:0]  b;
    r = '0;
    r.status = lfdo_pkg::ST_OK;
    case (w.req)
      lfdo_pkg::REQ_BEGIN: begin
        n = 32'(w.len);
        cap = 1'b0;
        bytes_left = 0;
        cut_line = 1'b0;
        if (n >= line_cap()) begin
          n = line_cap() - 1;
          cap = 1'b1;
        end
        if (n > lfdo_pkg::DEPTH) begin
          r.status = lfdo_pkg::ST_TOO_LONG;
        end else if (n > 0) begin
          while (lfdo_pkg::DEPTH - fill < n) drop_line();
          bytes_left = n;
          cut_line = cap;
        end
      end
      lfdo_pkg::REQ_WRITE: begin
        if (bytes_left == 0 || fill >= lfdo_pkg::DEPTH) begin
          r.status = lfdo_pkg::ST_IGNORED;
        end else begin
          b = w.data;
          if (cut_line && bytes_left == 1) b = lfdo_pkg::CHAR_NL;
          else if (b == lfdo_pkg::BYTE_FF) b = lfdo_pkg::CHAR_QM;
          fifo_mem[wr_ptr[IW-1:0]] = b;
          wr_ptr = (wr_ptr + 1) % lfdo_pkg::DEPTH;
          fill++;
          bytes_left--;
          if (bytes_left == 0) cut_line = 1'b0;
        end
      end
      lfdo_pkg::REQ_PEEK: begin
        if (w.off < fill) r.rd = fifo_mem[IW'((rd_ptr + w.off) % lfdo_pkg::DEPTH)];
        else r.status = lfdo_pkg::ST_IGNORED;
      end
      lfdo_pkg::REQ_CONSUME: begin
        n = 32'(w.cnt);
        if (n > fill) n = fill;
        rd_ptr = (rd_ptr + n) % lfdo_pkg::DEPTH;
        fill -= n;
      end
      lfdo_pkg::REQ_TAKE: begin
        r.dropped = drop_cnt;
        drop_cnt = '0;
      end
      default: begin
        r.status = lfdo_pkg::ST_IGNORED;
      end
    endcase
    r.used = fill[13:0];
    r.due = (fill >= cfg_thresh);
    return r;
  endfunction

  function automatic row_t it(logic [2:0] req, logic [15:0] len, logic [7:0] data,
                              logic [12:0] off, logic [13:0] cnt);
    row_t r;
    r = '0;
    r.w.req = req;
    r.w.len = len;
    r.w.data = data;
    r.w.off = off;
    r.w.cnt = cnt;
    return r;
  endfunction

  function automatic row_t itx(logic [2:0] req, logic [15:0] len, logic [7:0] data,
                               logic [12:0] off, logic [13:0] cnt, logic [1:0] st,
                               logic [7:0] rd, logic [13:0] used, logic [23:0] dc,
                               logic due);
    row_t r;
    r = it(req, len, data, off, cnt);
    r.typed = 1'b1;
    r.want.status = st;
    r.want.rd = rd;
    r.want.used = used;
    r.want.dropped = dc;
    r.want.due = due;
    return r;
  endfunction

  function automatic row_t cf(logic sel, logic [31:0] val);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cfg_sel = sel;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    w.req = 3'($urandom_range(0, 7));
    w.len = 16'($urandom);
    w.data = 8'($urandom);
    w.off = 13'($urandom);
    w.cnt = 14'($urandom);
    return w;
  endfunction

  function automatic logic [7:0] rand_byte();
    int unsigned k;
    k = $urandom_range(0, 15);
    if (k == 0) return lfdo_pkg::BYTE_FF;
    if (k == 1) return lfdo_pkg::CHAR_NL;
    return 8'($urandom);
  endfunction

  // entered and left at a falling edge
  task automatic send_word(word_t w, logic typed, result_t want);
    result_t p;
    while (!steady && $urandom_range(0, 99) < 22) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    p = fifo_step(w);
    pending_results.push_back(typed ? want : p);
    req_type_i = w.req;
    line_len_i = w.len;
    data_byte_i = w.data;
    peek_offset_i = w.off;
    consume_count_i = w.cnt;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic reg_write(logic sel, logic [31:0] val);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {sel, 2'b00};
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (sel == lfdo_pkg::REG_THRESH) cfg_thresh = 32'(val[13:0]);
    else cfg_max_line = 32'(val[8:0]);
  endtask

  task automatic set_regs(logic [31:0] thresh, logic [31:0] max_line);
    reg_write(lfdo_pkg::REG_THRESH, thresh);
    reg_write(lfdo_pkg::REG_MAX_LINE, max_line);
  endtask

  task automatic send_rand(word_t w);
    send_word(w, 1'b0, '0);
  endtask

  // deep: long lines and small consumes, so that old lines get dropped
  task automatic random_traffic(int n, logic deep);
    int          sent;
    int unsigned k;
    int unsigned m;
    int unsigned nb;
    word_t       w;
    sent = 0;
    while (sent < n) begin
      k = $urandom_range(0, 99);
      w = rand_word();
      m = line_cap();
      if (k < 50) begin
        w.req = lfdo_pkg::REQ_BEGIN;
        case ($urandom_range(0, 9))
          0: w.len = 16'($urandom);
          1, 2: w.len = 16'($urandom_range(m - 1, m + 1));
          default: begin
            if (deep) w.len = 16'($urandom_range(m / 2, m - 1));
            else w.len = 16'($urandom_range(1, (m - 1 < 20) ? m - 1 : 20));
          end
        endcase
        nb = (32'(w.len) >= m) ? m - 1 : 32'(w.len);
        send_rand(w);
        sent++;
        k = $urandom_range(0, 9);
        if (k == 0) nb = $urandom_range(0, nb);
        else if (k == 1) nb += $urandom_range(1, 3);
        repeat (nb) begin
          w = rand_word();
          w.req = lfdo_pkg::REQ_WRITE;
          w.data = rand_byte();
          send_rand(w);
          sent++;
        end
      end else if (k < 65) begin
        w.req = lfdo_pkg::REQ_PEEK;
        if (fill > 0 && $urandom_range(0, 9) != 0) w.off = 13'($urandom_range(0, fill - 1));
        send_rand(w);
        sent++;
      end else if (k < 78) begin
        w.req = lfdo_pkg::REQ_CONSUME;
        if (deep) w.cnt = 14'($urandom_range(0, 8));
        else if ($urandom_range(0, 9) != 0) w.cnt = 14'($urandom_range(0, fill + 4));
        send_rand(w);
        sent++;
      end else if (k < 85) begin
        w.req = lfdo_pkg::REQ_TAKE;
        send_rand(w);
        sent++;
      end else if (k < 92) begin
        w.req = lfdo_pkg::REQ_WRITE;
        send_rand(w);
      end else begin
        w.req = 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
        send_rand(w);
      end
    end
  endtask

  // whole lines until the fifo is nearly full
  task automatic fill_up(int unsigned target);
    word_t       w;
    int unsigned nb;
    while (fill < target) begin
      w = rand_word();
      w.req = lfdo_pkg::REQ_BEGIN;
      w.len = 16'($urandom_range(60, 400));
      nb = (32'(w.len) >= line_cap()) ? line_cap() - 1 : 32'(w.len);
      send_rand(w);
      repeat (nb) begin
        w = rand_word();
        w.req = lfdo_pkg::REQ_WRITE;
        w.data = rand_byte();
        send_rand(w);
      end
    end
  endtask

  // receiver side
  initial begin
    out_stall_i = 1'b0;
    holdoff_seen = 0;
    holdoff_left = 0;
    forever begin
      @(negedge clk_i);
      if (holdoff_seen != holdoff_asks) begin
        holdoff_seen = holdoff_asks;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        out_stall_i = 1'b1;
        holdoff_left--;
      end else begin
        out_stall_i = !steady && ($urandom_range(0, 99) < 22);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          errors++;
        end
        if (read_byte_o !== e.rd) begin
          $error("read_byte: expected %0h, got %0h", e.rd, read_byte_o);
          errors++;
        end
        if (used_bytes_o !== e.used) begin
          $error("used_bytes: expected %0d, got %0d", e.used, used_bytes_o);
          errors++;
        end
        if (dropped_count_o !== e.dropped) begin
          $error("dropped_count: expected %0d, got %0d", e.dropped, dropped_count_o);
          errors++;
        end
        if (flush_due_o !== e.due) begin
          $error("flush_due: expected %0d, got %0d", e.due, flush_due_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    steady = 1'b0;
    holdoff_asks = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = '0;
    line_len_i = '0;
    data_byte_i = '0;
    peek_offset_i = '0;
    consume_count_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    wr_ptr = 0;
    rd_ptr = 0;
    fill = 0;
    drop_cnt = '0;
    bytes_left = 0;
    cut_line = 1'b0;
    cfg_thresh = 32'(lfdo_pkg::THRESH_RST);
    cfg_max_line = 32'(lfdo_pkg::MAX_LINE_RST);

    dir_rows.push_back(itx(lfdo_pkg::REQ_TAKE, 0, 0, 0, 0, lfdo_pkg::ST_OK, 0, 0, 0, 0));
    dir_rows.push_back(itx(lfdo_pkg::REQ_PEEK, 0, 0, 0, 0,
                           lfdo_pkg::ST_IGNORED, 0, 0, 0, 0));
    dir_rows.push_back(itx(lfdo_pkg::REQ_WRITE, 0, 8'h41, 0, 0,
                           lfdo_pkg::ST_IGNORED, 0, 0, 0, 0));
    dir_rows.push_back(itx(lfdo_pkg::REQ_CONSUME, 0, 0, 0, 14'h3FFF,
                           lfdo_pkg::ST_OK, 0, 0, 0, 0));
    dir_rows.push_back(itx(REQ_UNUSED_LAST, 16'hFFFF, 8'hFF, 13'h1FFF, 14'h3FFF,
                           lfdo_pkg::ST_IGNORED, 0, 0, 0, 0));
    // zero length opens no line
    dir_rows.push_back(itx(lfdo_pkg::REQ_BEGIN, 0, 0, 0, 0, lfdo_pkg::ST_OK, 0, 0, 0, 0));
    dir_rows.push_back(itx(lfdo_pkg::REQ_WRITE, 0, lfdo_pkg::BYTE_FF, 0, 0,
                           lfdo_pkg::ST_IGNORED, 0, 0, 0, 0));
    dir_rows.push_back(itx(lfdo_pkg::REQ_BEGIN, 16'hFFFF, 0, 0, 0,
                           lfdo_pkg::ST_OK, 0, 0, 0, 0));
    dir_rows.push_back(itx(lfdo_pkg::REQ_WRITE, 0, lfdo_pkg::BYTE_FF, 0, 0,
                           lfdo_pkg::ST_OK, 0, 1, 0, 0));
    dir_rows.push_back(it(lfdo_pkg::REQ_WRITE, 0, 8'h00, 0, 0));
    // begin while a line is open
    dir_rows.push_back(it(lfdo_pkg::REQ_BEGIN, 2, 0, 0, 0));
    dir_rows.push_back(it(lfdo_pkg::REQ_WRITE, 0, 8'h7F, 0, 0));
    dir_rows.push_back(it(lfdo_pkg::REQ_WRITE, 0, lfdo_pkg::CHAR_NL, 0, 0));
    dir_rows.push_back(itx(lfdo_pkg::REQ_PEEK, 0, 0, 0, 0,
                           lfdo_pkg::ST_OK, lfdo_pkg::CHAR_QM, 4, 0, 0));
    dir_rows.push_back(itx(lfdo_pkg::REQ_PEEK, 0, 0, 13'h1FFF, 0,
                           lfdo_pkg::ST_IGNORED, 0, 4, 0, 0));
    dir_rows.push_back(it(REQ_UNUSED_FIRST, 0, 0, 0, 0));
    // short lines: cut, newline forced, surplus ignored
    dir_rows.push_back(cf(lfdo_pkg::REG_MAX_LINE, 4));
    dir_rows.push_back(cf(lfdo_pkg::REG_THRESH, 1));
    dir_rows.push_back(it(lfdo_pkg::REQ_BEGIN, 9, 0, 0, 0));
    dir_rows.push_back(it(lfdo_pkg::REQ_WRITE, 0, 8'h41, 0, 0));
    dir_rows.push_back(it(lfdo_pkg::REQ_WRITE, 0, lfdo_pkg::BYTE_FF, 0, 0));
    dir_rows.push_back(it(lfdo_pkg::REQ_WRITE, 0, 8'h42, 0, 0));
    dir_rows.push_back(it(lfdo_pkg::REQ_WRITE, 0, 8'h43, 0, 0));
    dir_rows.push_back(it(lfdo_pkg::REQ_PEEK, 0, 0, 6, 0));
    dir_rows.push_back(it(lfdo_pkg::REQ_CONSUME, 0, 0, 0, 3));
    dir_rows.push_back(it(lfdo_pkg::REQ_TAKE, 0, 0, 0, 0));
    // out of range registers
    dir_rows.push_back(cf(lfdo_pkg::REG_MAX_LINE, 0));
    dir_rows.push_back(cf(lfdo_pkg::REG_THRESH, 0));
    dir_rows.push_back(it(lfdo_pkg::REQ_BEGIN, 5, 0, 0, 0));
    dir_rows.push_back(it(lfdo_pkg::REQ_WRITE, 0, 8'h55, 0, 0));
    dir_rows.push_back(it(lfdo_pkg::REQ_CONSUME, 0, 0, 0, 14'h3FFF));
    dir_rows.push_back(cf(lfdo_pkg::REG_MAX_LINE, 9'h1FF));
    dir_rows.push_back(cf(lfdo_pkg::REG_THRESH, 8192));
    dir_rows.push_back(it(lfdo_pkg::REQ_BEGIN, 300, 0, 0, 0));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) reg_write(dir_rows[i].cfg_sel, dir_rows[i].cfg_val);
      else send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
    end

    set_regs(1, 2);
    random_traffic(80, 1'b0);

    set_regs(8192, 256);
    fill_up(7900);
    steady = 1'b1;
    random_traffic(150, 1'b1);
    steady = 1'b0;

    set_regs(40, 16);
    steady = 1'b1;
    holdoff_asks++;
    random_traffic(30, 1'b0);
    steady = 1'b0;
    random_traffic(90, 1'b0);

    set_regs(300, 100);
    random_traffic(120, 1'b0);

    set_regs($urandom_range(1, 8192), $urandom_range(2, 511));
    random_traffic(100, 1'b0);

    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/lfdo_pkg.sv
hdl/lfdo_front.sv
hdl/lfdo_queue.sv
hdl/lfdo_back.sv
hdl/line_fifo_drop_oldest_top.sv
tb/line_fifo_drop_oldest_top_test.sv
